>>> hw/rtl/sia_pkg.sv
// ---------------------------------------------------------------------------
// sia_pkg
// Shared constants and controller/datapath interface types for the
// signed integer to decimal ASCII converter.
// ---------------------------------------------------------------------------
package sia_pkg;

   localparam int BIN_W      = 32;
   localparam int NUM_DIGITS = 10;
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int IDX_W      = 4;
   localparam int STEP_W     = 5;
   localparam int CHAR_W     = 8;

   localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(BIN_W - 1);
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

   typedef struct packed {
      logic load;      // capture input beat
      logic shift;     // one double-dabble step
      logic scan;      // find leading digit
      logic dec;       // advance to next lower digit
      logic sel_sign;  // present '-' instead of a digit
   } cmd_type;

   typedef struct packed {
      logic neg;       // captured value was negative
      logic idx_zero;  // current digit is the least significant
   } stat_type;

endpackage

>>> hw/rtl/sia_datapath.sv
// ---------------------------------------------------------------------------
// sia_datapath
// Magnitude register, shift-and-add-3 BCD converter, leading digit
// index and character selection.
// ---------------------------------------------------------------------------
module sia_datapath
   import sia_pkg::*;
(
   input  logic              clock,
   input  cmd_type           cmd,
   input  logic [BIN_W-1:0]  value,
   output stat_type          stat,
   output logic [CHAR_W-1:0] char_code
);

   logic [BIN_W-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [BCD_W-1:0] bcd_adj;
   logic             neg_ff, neg_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] lead_idx;
   logic [3:0]       cur_digit;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      lead_idx = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            lead_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      neg_in = neg_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         neg_in = value[BIN_W-1];
         mag_in = value[BIN_W-1] ? (BIN_W'(0) - value) : value;
         bcd_in = '0;
      end else if (cmd.shift) begin
         bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[BIN_W-1]};
         mag_in = {mag_ff[BIN_W-2:0], 1'b0};
      end else if (cmd.scan) begin
         idx_in = lead_idx;
      end else if (cmd.dec) begin
         idx_in = idx_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
      idx_ff <= idx_in;
   end

   assign cur_digit     = bcd_ff[idx_ff*4 +: 4];
   assign char_code     = cmd.sel_sign ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(cur_digit));
   assign stat.neg      = neg_ff;
   assign stat.idx_zero = (idx_ff == '0);

endmodule

>>> hw/rtl/sia_controller.sv
// ---------------------------------------------------------------------------
// sia_controller
// Sequencer: capture, 32 conversion steps, leading digit scan, then one
// output beat per character.
// ---------------------------------------------------------------------------
module sia_controller
   import sia_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output logic     rsp_tlast,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_DIGIT = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      rsp_tlast    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.shift = 1'b1;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = stat.neg ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            cmd.sel_sign = 1'b1;
            rsp_tvalid   = 1'b1;
            if (rsp_tready) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = stat.idx_zero;
            if (rsp_tready) begin
               if (stat.idx_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.dec = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

>>> hw/rtl/signed_int_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a 32-bit two's complement integer to decimal ASCII text.
//
// req channel: one beat carries the integer. rsp channel: one beat per
// character, '-' first for negative values, then digits most significant
// first without leading zeros; tlast marks the final character.
// One integer is handled at a time: req_tready is high only when idle.
// After a beat is taken the unsigned 32-bit magnitude runs through 32
// shift-and-add-3 steps (one per cycle), then a scan state finds the
// leading digit, then one character is offered per cycle while
// rsp_tready is high. An integer yields N characters, N from 1 to 11.
// A stall holds the current character and tlast steady until taken.
// Synchronous reset returns the sequencer to idle and drops rsp_tvalid.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii
   import sia_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BIN_W-1:0]  req_tdata,   // [31:0] value
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [CHAR_W-1:0] rsp_tdata,   // [7:0] char_code
   output logic              rsp_tlast    // last_char
);

   cmd_type  cmd;
   stat_type stat;

   sia_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .stat       (stat),
      .cmd        (cmd)
   );

   sia_datapath u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .value     (req_tdata),
      .stat      (stat),
      .char_code (rsp_tdata)
   );

endmodule
